@@ sv/gmc_pkg.sv @@
`timescale 1ns / 1ps
// Package for the gas median calibrator: controller state codes, field widths,
// register indexes and register reset values. No dependencies.
package gmc_pkg;

  localparam int SAMPLE_W  = 17;
  localparam int GAIN_W    = 16;
  localparam int CONC_W    = 24;
  localparam int DIFF_W    = SAMPLE_W + 1;
  localparam int PROD_W    = DIFF_W + GAIN_W;
  localparam int FRAC_BITS = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 17;

  localparam logic [CFG_IDX_W-1:0] REG_ZERO_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_NEG   = 2'd2;

  localparam logic signed [SAMPLE_W-1:0] ZERO_OFFSET_RST = 17'sd2096;
  localparam logic signed [GAIN_W-1:0]   GAIN_RST        = 16'sd731;
  localparam logic                       CLAMP_NEG_RST   = 1'b1;

  localparam logic signed [CONC_W-1:0] CONC_MAX = 24'sh7FFFFF;
  localparam logic signed [CONC_W-1:0] CONC_MIN = 24'sh800000;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_OLD  = 9'b000000010,
    S_DEL  = 9'b000000100,
    S_INS  = 9'b000001000,
    S_FIN  = 9'b000010000,
    S_MRD  = 9'b000100000,
    S_MDAT = 9'b001000000,
    S_MUL  = 9'b010000000,
    S_RES  = 9'b100000000
  } state_t;

endpackage

@@ sv/gas_median_calibrator.sv @@
`timescale 1ns / 1ps
// Top level of the gas median calibrator: running median over a sample window
// and linear calibration to a concentration. Depends on gmc_pkg.

// The block keeps the last WINDOW valid samples in two single-port-read
// memories: a circular history, which tells which sample leaves the window,
// and a copy kept in ascending order. For each valid item the controller
// reads the leaving sample, walks the sorted memory once upward to remove it
// (only once the window is full) and once downward to insert the new sample,
// then reads the middle entry of the filled part. The median is converted as
// ((median - zero_offset) * gain) >> 8 with a floor shift, saturated to 24
// bits and optionally clamped at zero. The time a valid item takes from
// acceptance until its result is offered is set by the one read port of the
// sorted memory that both passes walk entry by entry; it is shorter when the
// new sample finds its place early in the downward pass and during warm-up.
// An invalid item leaves the history and sorted memories untouched and yields
// an all-zero result with result_valid low. A new item is taken whenever the
// controller is idle, even while the previous result still waits in the
// output register. Configuration writes are always taken and are meant to be
// issued only while no item is in flight; unknown register indexes are ignored.
module gas_median_calibrator
  import gmc_pkg::*;
#(
  parameter int WINDOW = 7
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample_mv,
  input  logic                       in_sample_valid,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_median_mv,
  output logic signed [CONC_W-1:0]   out_conc_ppb,
  output logic                       out_result_valid,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data
);

  localparam int AW = $clog2(WINDOW);
  localparam int CW = $clog2(WINDOW + 1);
  localparam logic [CW-1:0] WIN_FULL = CW'(WINDOW);
  localparam logic [AW-1:0] WP_LAST  = AW'(WINDOW - 1);

  // Configuration registers.
  logic signed [SAMPLE_W-1:0] zero_r;
  logic signed [GAIN_W-1:0]   gain_r;
  logic                       clamp_r;

  // Control state.
  state_t        state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [CW-1:0] len_r, len_nxt;
  logic [CW-1:0] iss_r, iss_nxt;
  logic          pend_r, pend_nxt;
  logic [AW-1:0] pidx_r, pidx_nxt;
  logic          found_r, found_nxt;
  logic          placed_r, placed_nxt;
  logic          res_ok_r, res_ok_nxt;

  // Datapath registers.
  logic signed [SAMPLE_W-1:0] samp_r, samp_nxt;
  logic signed [SAMPLE_W-1:0] old_r, old_nxt;
  logic signed [SAMPLE_W-1:0] med_r, med_nxt;
  logic signed [PROD_W-1:0]   prod_r, prod_nxt;

  // Output register.
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_med_r, out_med_nxt;
  logic signed [CONC_W-1:0]   out_conc_r, out_conc_nxt;
  logic                       out_ok_r, out_ok_nxt;

  // Memories: circular history and sorted copy.
  logic signed [SAMPLE_W-1:0] win_mem [WINDOW];
  logic signed [SAMPLE_W-1:0] srt_mem [WINDOW];
  logic signed [SAMPLE_W-1:0] win_rd_r;
  logic signed [SAMPLE_W-1:0] srt_rd_r;
  logic                       win_we;
  logic                       srt_we;
  logic [AW-1:0]              srt_wa;
  logic [AW-1:0]              srt_ra;
  logic signed [SAMPLE_W-1:0] srt_wd;

  // Calibration arithmetic.
  logic signed [DIFF_W-1:0]           diff;
  logic signed [PROD_W-FRAC_BITS-1:0] scaled;
  logic signed [CONC_W-1:0]           conc_sat;

  assign in_ready         = (state_r == S_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_median_mv    = out_med_r;
  assign out_conc_ppb     = out_conc_r;
  assign out_result_valid = out_ok_r;

  assign diff   = DIFF_W'(med_r) - DIFF_W'(zero_r);
  assign scaled = prod_r[PROD_W-1:FRAC_BITS];

  always_comb begin
    if (scaled > (PROD_W-FRAC_BITS)'(CONC_MAX)) begin
      conc_sat = CONC_MAX;
    end else if (scaled < (PROD_W-FRAC_BITS)'(CONC_MIN)) begin
      conc_sat = CONC_MIN;
    end else begin
      conc_sat = scaled[CONC_W-1:0];
    end
    if (clamp_r && conc_sat[CONC_W-1]) begin
      conc_sat = '0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    wp_nxt        = wp_r;
    len_nxt       = len_r;
    iss_nxt       = iss_r;
    pend_nxt      = 1'b0;
    pidx_nxt      = pidx_r;
    found_nxt     = found_r;
    placed_nxt    = placed_r;
    res_ok_nxt    = res_ok_r;
    samp_nxt      = samp_r;
    old_nxt       = old_r;
    med_nxt       = med_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_med_nxt   = out_med_r;
    out_conc_nxt  = out_conc_r;
    out_ok_nxt    = out_ok_r;
    win_we        = 1'b0;
    srt_we        = 1'b0;
    srt_wa        = '0;
    srt_wd        = samp_r;
    srt_ra        = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          samp_nxt   = in_sample_mv;
          res_ok_nxt = in_sample_valid;
          state_nxt  = in_sample_valid ? S_OLD : S_RES;
        end
      end
      S_OLD: begin
        // The history read of the write position lands now.
        old_nxt  = win_rd_r;
        win_we   = 1'b1;
        wp_nxt   = (wp_r == WP_LAST) ? '0 : wp_r + AW'(1);
        iss_nxt  = '0;
        if (fill_r == WIN_FULL) begin
          len_nxt   = WIN_FULL;
          found_nxt = 1'b0;
          state_nxt = S_DEL;
        end else begin
          len_nxt    = fill_r;
          fill_nxt   = fill_r + CW'(1);
          placed_nxt = 1'b0;
          state_nxt  = S_INS;
        end
      end
      S_DEL: begin
        // Upward pass: drop the first copy of the leaving sample and shift
        // everything above it down by one place.
        if (iss_r < len_r) begin
          srt_ra   = iss_r[AW-1:0];
          pidx_nxt = iss_r[AW-1:0];
          iss_nxt  = iss_r + CW'(1);
          pend_nxt = 1'b1;
        end
        if (pend_r) begin
          if (found_r) begin
            srt_we = 1'b1;
            srt_wa = pidx_r - AW'(1);
            srt_wd = srt_rd_r;
          end else if (srt_rd_r == old_r) begin
            found_nxt = 1'b1;
          end
        end
        if (!pend_r && iss_r == len_r) begin
          len_nxt    = len_r - CW'(1);
          iss_nxt    = '0;
          placed_nxt = 1'b0;
          state_nxt  = S_INS;
        end
      end
      S_INS: begin
        // Downward pass: move larger entries up until the new sample fits.
        if (iss_r < len_r && !placed_r) begin
          srt_ra   = AW'(len_r - CW'(1) - iss_r);
          pidx_nxt = AW'(len_r - CW'(1) - iss_r);
          iss_nxt  = iss_r + CW'(1);
          pend_nxt = 1'b1;
        end
        if (pend_r && !placed_r) begin
          srt_we = 1'b1;
          srt_wa = pidx_r + AW'(1);
          if (srt_rd_r > samp_r) begin
            srt_wd = srt_rd_r;
          end else begin
            srt_wd     = samp_r;
            placed_nxt = 1'b1;
          end
        end
        if (!pend_r && (iss_r == len_r || placed_r)) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!placed_r) begin
          srt_we = 1'b1;
          srt_wa = '0;
          srt_wd = samp_r;
        end
        state_nxt = S_MRD;
      end
      S_MRD: begin
        srt_ra    = AW'(fill_r >> 1);
        state_nxt = S_MDAT;
      end
      S_MDAT: begin
        med_nxt   = srt_rd_r;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = PROD_W'(diff) * PROD_W'(gain_r);
        state_nxt = S_RES;
      end
      S_RES: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_med_nxt   = res_ok_r ? med_r : '0;
          out_conc_nxt  = res_ok_r ? conc_sat : '0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      wp_r        <= '0;
      len_r       <= '0;
      iss_r       <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      placed_r    <= 1'b0;
      res_ok_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      wp_r        <= wp_nxt;
      len_r       <= len_nxt;
      iss_r       <= iss_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      placed_r    <= placed_nxt;
      res_ok_r    <= res_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r     <= pidx_nxt;
    samp_r     <= samp_nxt;
    old_r      <= old_nxt;
    med_r      <= med_nxt;
    prod_r     <= prod_nxt;
    out_med_r  <= out_med_nxt;
    out_conc_r <= out_conc_nxt;
    out_ok_r   <= out_ok_nxt;
  end

  // Configuration registers; values wider than a register are truncated.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_r  <= ZERO_OFFSET_RST;
      gain_r  <= GAIN_RST;
      clamp_r <= CLAMP_NEG_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ZERO_OFFSET: zero_r  <= cfg_data[SAMPLE_W-1:0];
        REG_GAIN:        gain_r  <= cfg_data[GAIN_W-1:0];
        REG_CLAMP_NEG:   clamp_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // History memory: always reads the current write position.
  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[wp_r] <= samp_r;
    end
    win_rd_r <= win_mem[wp_r];
  end

  // Sorted memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (srt_we) begin
      srt_mem[srt_wa] <= srt_wd;
    end
    srt_rd_r <= srt_mem[srt_ra];
  end

  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= WIN_FULL)
    else $error("fill count beyond window size");

  a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= WP_LAST)
    else $error("write position beyond window");

  a_del_found: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEL && !pend_r && iss_r == len_r) |-> found_r)
    else $error("leaving sample not present in sorted memory");

  a_pend_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == S_DEL || state_r == S_INS))
    else $error("read pending outside a scan pass");

  a_median_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MRD) |-> (fill_r != '0))
    else $error("median read from an empty window");

endmodule
